// ===== hdl/tgr_pkg.sv =====
// Package with shared types, constants and the pointer gain table of the gesture recognizer.
`default_nettype none
package tgr_pkg;

  localparam int MAX_FINGERS      = 8;
  localparam int GAIN_TABLE_DEPTH = 256;

  localparam int SLOT_W   = $clog2(MAX_FINGERS);
  localparam int CNT_W    = $clog2(MAX_FINGERS + 1);
  localparam int IDX_W    = $clog2(GAIN_TABLE_DEPTH);
  localparam int SQ_W     = 2 * IDX_W;
  localparam int GAIN_W   = 16;
  localparam int SQ_LIMIT = (GAIN_TABLE_DEPTH - 1) * (GAIN_TABLE_DEPTH - 1)
                          + (GAIN_TABLE_DEPTH - 1);

  localparam logic [63:0] RECIP_5 = 64'hCCCCCCCD;

  localparam logic [1:0] CFG_MOVE_THR  = 2'd0;
  localparam logic [1:0] CFG_CLS_INT   = 2'd1;
  localparam logic [1:0] CFG_TAP_WIN   = 2'd2;

  typedef enum logic [1:0] {
    OP_DOWN = 2'd0,
    OP_MOVE = 2'd1,
    OP_UP   = 2'd2,
    OP_TICK = 2'd3
  } tgr_op_e;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_LEFT      = 4'd1,
    ST_POTDBL    = 4'd2,
    ST_DOUBLE    = 4'd3,
    ST_MOVE      = 4'd4,
    ST_ADDMOVE   = 4'd5,
    ST_RIGHT     = 4'd6,
    ST_SEARCH    = 4'd7,
    ST_ACTION    = 4'd8,
    ST_DRAGSTART = 4'd9,
    ST_ZOOM      = 4'd10,
    ST_SCROLL    = 4'd11,
    ST_TWO       = 4'd12,
    ST_THREE     = 4'd13,
    ST_FOUR      = 4'd14,
    ST_DRAGEND   = 4'd15
  } tgr_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_PUSHG,
    CMD_CLA,
    CMD_CLB,
    CMD_CLM,
    CMD_CLD,
    CMD_SQ,
    CMD_SUM,
    CMD_SQRT,
    CMD_IDX,
    CMD_GAIN,
    CMD_MUL,
    CMD_PUSHP
  } tgr_cmd_e;

  typedef struct packed {
    logic gpend;
    logic cpend;
    logic ppend;
    logic cls_ok;
    logic sqrt_done;
    logic out_free;
  } tgr_status_t;

  typedef logic [GAIN_W-1:0] gain_tab_t [GAIN_TABLE_DEPTH];

  function automatic logic [4:0] gcode(tgr_state_e s);
    return 5'({1'b0, s}) + 5'd1;
  endfunction

  function automatic logic [31:0] log2_q16(logic [31:0] v);
    logic [31:0] n;
    logic [31:0] frac;
    logic [63:0] m;
    n = 32'd0;
    frac = 32'd0;
    if (v == 32'd0) return 32'd0;
    while (n < 32'd31 && (v >> n) > 32'd1) n = n + 32'd1;
    m = ({32'd0, v} << 30) >> n;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[b] = 1'b1;
      end
    end
    return (n << 16) | frac;
  endfunction

  function automatic logic [63:0] div_small(logic [63:0] t, int j);
    logic [63:0] r;
    case (j)
      2:       r = t / 2;
      3:       r = t / 3;
      4:       r = t / 4;
      5:       r = t / 5;
      6:       r = t / 6;
      7:       r = t / 7;
      8:       r = t / 8;
      9:       r = t / 9;
      10:      r = t / 10;
      11:      r = t / 11;
      12:      r = t / 12;
      default: r = t;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] exp2_q30(logic [31:0] e);
    logic [31:0] k;
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    k = e >> 16;
    y = ({48'd0, e[15:0]} * 64'd744261118) >> 16;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int j = 1; j <= 12; j++) begin
      term = div_small((term * y) >> 30, j);
      sum = sum + term;
    end
    if (k > 32'd20) k = 32'd20;
    return sum << k;
  endfunction

  function automatic gain_tab_t build_gain_table();
    gain_tab_t t;
    logic [31:0] l;
    logic [31:0] e;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] g;
    t[0] = '0;
    for (int i = 1; i < GAIN_TABLE_DEPTH; i++) begin
      l = log2_q16(32'(60 * i));
      q = 64'(l - (32'd4 << 16)) * 64'd13;
      e = 32'((q * RECIP_5) >> 36);
      p = exp2_q30(e);
      q = (p * 64'd512 + (64'd5 << 29)) >> 30;
      g = (q * RECIP_5) >> 34;
      t[i] = GAIN_W'(g);
    end
    return t;
  endfunction

  localparam gain_tab_t GAIN_TABLE = build_gain_table();

endpackage
`default_nettype wire

// ===== hdl/tgr_ctrl.sv =====
// Controller state machine that sequences event handling, classification and pointer scaling.
`default_nettype none
module tgr_ctrl import tgr_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  tgr_status_t status_i,
  output tgr_cmd_e    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ROUTE, S_PUSHG, S_CLA, S_CLB, S_CLM, S_CLD,
    S_SQ, S_SUM, S_SQRT, S_IDX, S_GAIN, S_MUL, S_PUSHP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = CMD_LOAD;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o = CMD_EXEC;
        state_d = S_ROUTE;
      end
      S_ROUTE: begin
        if (status_i.gpend) state_d = S_PUSHG;
        else if (status_i.cpend) state_d = S_CLA;
        else if (status_i.ppend) state_d = S_SQ;
        else state_d = S_IDLE;
      end
      S_PUSHG: begin
        if (status_i.out_free) begin
          cmd_o = CMD_PUSHG;
          state_d = status_i.ppend ? S_SQ : S_IDLE;
        end
      end
      S_CLA: begin
        cmd_o = CMD_CLA;
        state_d = status_i.cls_ok ? S_CLB : S_IDLE;
      end
      S_CLB: begin
        cmd_o = CMD_CLB;
        state_d = S_CLM;
      end
      S_CLM: begin
        cmd_o = CMD_CLM;
        state_d = S_CLD;
      end
      S_CLD: begin
        cmd_o = CMD_CLD;
        state_d = S_IDLE;
      end
      S_SQ: begin
        cmd_o = CMD_SQ;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o = CMD_SUM;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (status_i.sqrt_done) state_d = S_IDX;
        else cmd_o = CMD_SQRT;
      end
      S_IDX: begin
        cmd_o = CMD_IDX;
        state_d = S_GAIN;
      end
      S_GAIN: begin
        cmd_o = CMD_GAIN;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o = CMD_MUL;
        state_d = S_PUSHP;
      end
      S_PUSHP: begin
        if (status_i.out_free) begin
          cmd_o = CMD_PUSHP;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tgr_datapath.sv =====
// Datapath with finger slots, gesture state, tap timer, classifier and pointer gain arithmetic.
`default_nettype none
module tgr_datapath import tgr_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  tgr_cmd_e           cmd_i,
  output tgr_status_t        status_o,
  input  wire         [1:0]  in_op_i,
  input  wire         [2:0]  in_finger_i,
  input  wire  signed [15:0] in_pos_x_i,
  input  wire  signed [15:0] in_pos_y_i,
  input  wire                cfg_we_i,
  input  wire         [1:0]  cfg_idx_i,
  input  wire         [15:0] cfg_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic        [4:0]  out_code_o,
  output logic signed [15:0] out_dx_o,
  output logic signed [15:0] out_dy_o,
  output logic               out_last_o
);

  logic [11:0] thr_q;
  logic [3:0]  cint_q;
  logic [15:0] twin_q;

  tgr_op_e            op_q;
  logic [2:0]         f_q;
  logic signed [15:0] px_q, py_q;

  tgr_state_e       st_q, st_n, st_mid, st_rep;
  logic [3:0]       cnt_q, cnt_n, cnt_inc;
  logic [MAX_FINGERS-1:0] act_q;
  logic [15:0]      tmr_q, tmr_n;
  logic             tpend_q, tpend_n;

  logic [SLOT_W-1:0]  rank_q [MAX_FINGERS];
  logic signed [15:0] sx_q [MAX_FINGERS];
  logic signed [15:0] sy_q [MAX_FINGERS];
  logic signed [15:0] lx_q [MAX_FINGERS];
  logic signed [15:0] ly_q [MAX_FINGERS];

  logic       gpend_q, ppend_q, cpend_q, g_n, p_n, c_n;
  logic [4:0] gcode_q, gcode_n;

  logic signed [16:0] mdx_q, mdy_q;
  logic [33:0]        sqx_q, sqy_q;
  logic signed [33:0] sqx_s, sqy_s;
  logic               clamp_q;
  logic [SQ_W-1:0]    rem_q, root_q, bit_q;
  logic [SQ_W:0]      trial;
  logic [34:0]        sum_sq;
  logic [IDX_W-1:0]   m_q;
  logic [GAIN_W-1:0]  g_q;
  logic [32:0]        prx_q, pry_q;
  logic               negx_q, negy_q;

  logic signed [16:0] c0x_q, c0y_q, c1x_q, c1y_q;
  logic signed [33:0] p0_q, p1_q, p0_s, p1_s;
  logic               ang0_q, ang1_q;
  logic signed [34:0] dot;
  logic               dir_ok;

  logic [SLOT_W-1:0]  slot, rd_idx, a_idx, b_idx;
  logic               slot_ok, slot_act, a_ok, b_ok, moving;
  logic [CNT_W-1:0]   act_cnt, rem_cnt;
  logic signed [15:0] rd_sx, rd_sy, rd_lx, rd_ly;
  logic signed [16:0] sdx, sdy, thr_s, dlx, dly;

  function automatic logic [16:0] abs17(logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [15:0] sat16(logic [32:0] p, logic neg);
    logic [21:0] r;
    logic [15:0] o;
    r = 22'((34'(p) + 34'd2048) >> 12);
    if (neg) o = (r > 22'd32768) ? 16'h8000 : 16'(~r + 22'd1);
    else o = (r > 22'd32767) ? 16'h7fff : 16'(r);
    return o;
  endfunction

  assign slot = SLOT_W'(f_q);
  assign slot_ok = (32'(f_q) < 32'(MAX_FINGERS));
  assign slot_act = act_q[slot];

  always_comb begin
    act_cnt = '0;
    rem_cnt = '0;
    for (int i = 0; i < MAX_FINGERS; i++) begin
      act_cnt = act_cnt + CNT_W'(act_q[i]);
      if (SLOT_W'(i) != slot) rem_cnt = rem_cnt + CNT_W'(act_q[i]);
    end
  end

  always_comb begin
    a_idx = '0;
    b_idx = '0;
    a_ok = 1'b0;
    b_ok = 1'b0;
    for (int i = MAX_FINGERS - 1; i >= 0; i--) begin
      if (act_q[i] && rank_q[i] == SLOT_W'(0)) begin
        a_idx = SLOT_W'(i);
        a_ok = 1'b1;
      end
      if (act_q[i] && rank_q[i] == SLOT_W'(1)) begin
        b_idx = SLOT_W'(i);
        b_ok = 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd_i)
      CMD_CLA: rd_idx = a_idx;
      CMD_CLB: rd_idx = b_idx;
      default: rd_idx = slot;
    endcase
  end

  assign rd_sx = sx_q[rd_idx];
  assign rd_sy = sy_q[rd_idx];
  assign rd_lx = lx_q[rd_idx];
  assign rd_ly = ly_q[rd_idx];
  assign dlx = 17'(rd_lx) - 17'(rd_sx);
  assign dly = 17'(rd_ly) - 17'(rd_sy);

  assign sdx = 17'(px_q) - 17'(rd_sx);
  assign sdy = 17'(py_q) - 17'(rd_sy);
  assign thr_s = signed'({5'd0, thr_q});
  assign moving = (sdx > thr_s) || (sdx < -thr_s) || (sdy > thr_s) || (sdy < -thr_s);
  assign cnt_inc = cnt_q + 4'd1;

  always_comb begin
    st_n = st_q;
    st_mid = st_q;
    st_rep = st_q;
    cnt_n = cnt_q;
    tmr_n = tmr_q;
    tpend_n = tpend_q;
    g_n = 1'b0;
    p_n = 1'b0;
    c_n = 1'b0;
    gcode_n = 5'd0;
    case (op_q)
      OP_TICK: begin
        if (tpend_q) begin
          if (tmr_q <= 16'd1) begin
            tmr_n = 16'd0;
            tpend_n = 1'b0;
            if (st_q != ST_DRAGSTART && st_q != ST_DOUBLE) begin
              g_n = 1'b1;
              gcode_n = gcode(ST_LEFT);
              if (st_q == ST_POTDBL) st_n = ST_IDLE;
            end
          end else begin
            tmr_n = tmr_q - 16'd1;
          end
        end
      end
      OP_DOWN: begin
        if (slot_ok && !slot_act) begin
          case (st_q)
            ST_IDLE:   st_n = ST_LEFT;
            ST_POTDBL: st_n = ST_DOUBLE;
            ST_MOVE:   st_n = ST_ADDMOVE;
            ST_LEFT:   st_n = ST_RIGHT;
            ST_RIGHT:  st_n = ST_SEARCH;
            ST_SEARCH: st_n = ST_ACTION;
            default:   st_n = st_q;
          endcase
        end
      end
      OP_MOVE: begin
        if (slot_ok && slot_act) begin
          if (moving) begin
            case (st_q)
              ST_LEFT: st_mid = ST_MOVE;
              ST_DOUBLE: begin
                st_mid = ST_DRAGSTART;
                g_n = 1'b1;
                gcode_n = gcode(ST_DRAGSTART);
              end
              ST_RIGHT, ST_ADDMOVE: begin
                if (cnt_inc >= cint_q) begin
                  cnt_n = 4'd0;
                  c_n = 1'b1;
                end else begin
                  cnt_n = cnt_inc;
                end
              end
              ST_SEARCH: st_mid = ST_THREE;
              ST_ACTION: st_mid = ST_FOUR;
              default:   st_mid = st_q;
            endcase
          end
          st_n = st_mid;
          p_n = (st_mid == ST_MOVE) || (st_mid == ST_DRAGSTART);
        end
      end
      OP_UP: begin
        if (slot_ok && slot_act && rem_cnt == '0) begin
          if (st_q == ST_LEFT) begin
            st_n = ST_POTDBL;
            tpend_n = 1'b1;
            tmr_n = twin_q;
          end else begin
            case (st_q)
              ST_DOUBLE:    st_rep = ST_LEFT;
              ST_DRAGSTART: st_rep = ST_DRAGEND;
              ST_MOVE:      st_rep = ST_IDLE;
              default:      st_rep = st_q;
            endcase
            g_n = 1'b1;
            gcode_n = gcode(st_rep);
            st_n = ST_IDLE;
          end
        end
      end
      default: st_n = st_q;
    endcase
  end

  assign sqx_s = mdx_q * mdx_q;
  assign sqy_s = mdy_q * mdy_q;
  assign sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign p0_s = c0x_q * c1x_q;
  assign p1_s = c0y_q * c1y_q;
  assign dot = 35'(p0_q) + 35'(p1_q);
  assign dir_ok = (c0y_q == 17'sd0) || (c1y_q == 17'sd0) ||
                  ((c0y_q > 17'sd0) == (c1y_q > 17'sd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 12'd48;
      cint_q <= 4'd5;
      twin_q <= 16'd250;
      st_q <= ST_IDLE;
      cnt_q <= 4'd0;
      act_q <= '0;
      tmr_q <= 16'd0;
      tpend_q <= 1'b0;
      gpend_q <= 1'b0;
      ppend_q <= 1'b0;
      cpend_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MOVE_THR: thr_q <= cfg_data_i[11:0];
          CFG_CLS_INT:  cint_q <= cfg_data_i[3:0];
          CFG_TAP_WIN:  twin_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i == CMD_EXEC) begin
        st_q <= st_n;
        cnt_q <= cnt_n;
        tmr_q <= tmr_n;
        tpend_q <= tpend_n;
        gpend_q <= g_n;
        ppend_q <= p_n;
        cpend_q <= c_n;
        if (slot_ok && op_q == OP_DOWN && !slot_act) act_q[slot] <= 1'b1;
        if (slot_ok && op_q == OP_UP && slot_act) act_q[slot] <= 1'b0;
      end
      if (cmd_i == CMD_CLD) begin
        if (dot <= 35'sd0) st_q <= ST_ZOOM;
        else if (dir_ok && ang0_q && ang1_q) st_q <= ST_SCROLL;
        else st_q <= ST_TWO;
      end
      if (cmd_i == CMD_PUSHG || cmd_i == CMD_PUSHP) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      op_q <= tgr_op_e'(in_op_i);
      f_q <= in_finger_i;
      px_q <= in_pos_x_i;
      py_q <= in_pos_y_i;
    end
    if (cmd_i == CMD_EXEC) begin
      gcode_q <= gcode_n;
      mdx_q <= 17'(px_q) - 17'(rd_lx);
      mdy_q <= 17'(py_q) - 17'(rd_ly);
      if (slot_ok && op_q == OP_DOWN && !slot_act) begin
        rank_q[slot] <= SLOT_W'(act_cnt);
        sx_q[slot] <= px_q;
        sy_q[slot] <= py_q;
        lx_q[slot] <= px_q;
        ly_q[slot] <= py_q;
      end
      if (slot_ok && op_q == OP_MOVE && slot_act) begin
        lx_q[slot] <= px_q;
        ly_q[slot] <= py_q;
      end
      if (slot_ok && op_q == OP_UP && slot_act) begin
        for (int i = 0; i < MAX_FINGERS; i++) begin
          if (act_q[i] && rank_q[i] > rank_q[slot]) rank_q[i] <= rank_q[i] - SLOT_W'(1);
        end
      end
    end
    case (cmd_i)
      CMD_CLA: begin
        c0x_q <= dlx;
        c0y_q <= dly;
      end
      CMD_CLB: begin
        c1x_q <= dlx;
        c1y_q <= dly;
      end
      CMD_CLM: begin
        p0_q <= p0_s;
        p1_q <= p1_s;
        ang0_q <= (27'(abs17(c0y_q)) * 27'd1000) >= (27'(abs17(c0x_q)) * 27'd839);
        ang1_q <= (27'(abs17(c1y_q)) * 27'd1000) >= (27'(abs17(c1x_q)) * 27'd839);
      end
      CMD_SQ: begin
        sqx_q <= sqx_s;
        sqy_q <= sqy_s;
      end
      CMD_SUM: begin
        clamp_q <= sum_sq > 35'(SQ_LIMIT);
        rem_q <= sum_sq[SQ_W-1:0];
        root_q <= '0;
        bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      CMD_SQRT: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_q <= SQ_W'({1'b0, rem_q} - trial);
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      CMD_IDX: begin
        if (clamp_q) m_q <= IDX_W'(GAIN_TABLE_DEPTH - 1);
        else if (rem_q > root_q) m_q <= IDX_W'(root_q + SQ_W'(1));
        else m_q <= IDX_W'(root_q);
      end
      CMD_GAIN: g_q <= GAIN_TABLE[m_q];
      CMD_MUL: begin
        prx_q <= 33'(abs17(mdx_q)) * 33'(g_q);
        pry_q <= 33'(abs17(mdy_q)) * 33'(g_q);
        negx_q <= mdx_q < 17'sd0;
        negy_q <= mdy_q > 17'sd0;
      end
      CMD_PUSHG: begin
        out_code_o <= gcode_q;
        out_dx_o <= 16'sd0;
        out_dy_o <= 16'sd0;
        out_last_o <= !ppend_q;
      end
      CMD_PUSHP: begin
        out_code_o <= 5'd0;
        out_dx_o <= sat16(prx_q, negx_q);
        out_dy_o <= sat16(pry_q, negy_q);
        out_last_o <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status_o.gpend = gpend_q;
  assign status_o.cpend = cpend_q;
  assign status_o.ppend = ppend_q;
  assign status_o.cls_ok = a_ok && b_ok;
  assign status_o.sqrt_done = (bit_q == '0);
  assign status_o.out_free = !out_valid_o || out_ready_i;

endmodule
`default_nettype wire

// ===== hdl/touch_gesture_recognizer.sv =====
// Top level of the touch gesture recognizer: controller and datapath.
//
// Channel  Direction  Handshake                  Payload
// s_axis   in         tvalid/tready              tuser op, tdata finger/pos_x/pos_y
// m_axis   out        tvalid/tready, tlast       tuser msg_code, tdata move_dx/move_dy
// cfg      in         write enable, no wait      index, 16-bit data
//
// One event is handled at a time: it is loaded, executed and routed, and then
// pushes any result words; a moved event may first run the classifier steps or
// the square, sum, eight-step square root, index, gain and multiply steps.
// A result word waits in the output register and stalls the sequencer only when
// the next word is ready to go out. Reset clears the finger slots and state.
`default_nettype none
module touch_gesture_recognizer import tgr_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,   // finger[2:0], pos_x[18:3], pos_y[34:19], zero
  input  wire  [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // move_dx[15:0], move_dy[31:16]
  output logic [4:0]  m_axis_tuser_o,   // msg_code[4:0]
  output logic        m_axis_tlast_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);

  tgr_cmd_e    cmd;
  tgr_status_t status;
  logic signed [15:0] dx, dy;

  tgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tgr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (s_axis_tuser_i),
    .in_finger_i (s_axis_tdata_i[2:0]),
    .in_pos_x_i  (s_axis_tdata_i[18:3]),
    .in_pos_y_i  (s_axis_tdata_i[34:19]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_code_o  (m_axis_tuser_o),
    .out_dx_o    (dx),
    .out_dy_o    (dy),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {dy, dx};

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of the touch gesture recognizer with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
  import tgr_pkg::*;

  typedef struct {
    tgr_op_e     op;
    logic [2:0]  finger;
    logic [15:0] x;
    logic [15:0] y;
  } touch_ev_t;

  typedef struct {
    logic [4:0]  code;
    logic [15:0] dx;
    logic [15:0] dy;
    logic        last;
  } gesture_msg_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  touch_gesture_recognizer DUT (.*);

  touch_ev_t    pending_events[$];
  gesture_msg_t expected_msgs[$];
  int           errors = 0;
  int           send_idle = 0;
  int           recv_idle = 0;
  logic         rx_hold = 1'b0;
  int unsigned  cycles = 0;

  // Predictor copy of the registers and the recognizer state.
  logic [11:0]  thr_reg;
  logic [3:0]   interval_reg;
  logic [15:0]  tap_window_reg;
  tgr_state_e   gstate;
  logic [3:0]   cls_count;
  logic         active[MAX_FINGERS];
  int           rank[MAX_FINGERS];
  int           sx[MAX_FINGERS], sy[MAX_FINGERS], lx[MAX_FINGERS], ly[MAX_FINGERS];
  int           tap_left;
  logic         tap_armed;
  int unsigned  gain_lut[GAIN_TABLE_DEPTH];

  initial forever #2 clk_i = ~clk_i;

  function automatic longint unsigned log2_fix(longint unsigned v);
    longint unsigned n, frac, m;
    n = 0;
    frac = 0;
    while (n < 31 && (v >> n) > 1) n++;
    m = (v << 30) >> n;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac |= 64'd1 << b;
      end
    end
    return (n << 16) | frac;
  endfunction

  function automatic longint unsigned pow2_fix(longint unsigned e);
    longint unsigned k, y, acc, term;
    k = e >> 16;
    y = ((e & 64'hFFFF) * 64'd744261118) >> 16;
    acc = 64'd1 << 30;
    term = acc;
    for (int j = 1; j <= 12; j++) begin
      term = ((term * y) >> 30) / j;
      acc += term;
    end
    if (k > 20) k = 20;
    return acc << k;
  endfunction

  function automatic longint unsigned root_rounded(longint unsigned s);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= s) r |= 64'd1 << b;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic logic [15:0] apply_gain(int d, int unsigned g);
    longint unsigned mag, r;
    mag = (d < 0) ? -longint'(d) : longint'(d);
    r = (mag * g + 2048) >> 12;
    if (d < 0) return (r > 32768) ? 16'h8000 : 16'(-longint'(r));
    return (r > 32767) ? 16'h7FFF : 16'(r);
  endfunction

  function automatic gesture_msg_t gesture_word(tgr_state_e s);
    gesture_msg_t w;
    w.code = 5'(s) + 5'd1;
    w.dx = '0;
    w.dy = '0;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic int fingers_down();
    int c;
    c = 0;
    for (int i = 0; i < MAX_FINGERS; i++) if (active[i]) c++;
    return c;
  endfunction

  function automatic int slot_with_rank(int r);
    for (int i = 0; i < MAX_FINGERS; i++) if (active[i] && rank[i] == r) return i;
    return -1;
  endfunction

  task automatic classify_two();
    int a, b;
    longint x0, y0, x1, y1;
    logic dir_ok, steep0, steep1;
    a = slot_with_rank(0);
    b = slot_with_rank(1);
    if (a < 0 || b < 0) return;
    x0 = lx[a] - sx[a]; y0 = ly[a] - sy[a];
    x1 = lx[b] - sx[b]; y1 = ly[b] - sy[b];
    if (x0 * x1 + y0 * y1 <= 0) begin
      gstate = ST_ZOOM;
      return;
    end
    dir_ok = (y0 == 0) || (y1 == 0) || ((y0 > 0) == (y1 > 0));
    steep0 = 1000 * (y0 < 0 ? -y0 : y0) >= 839 * (x0 < 0 ? -x0 : x0);
    steep1 = 1000 * (y1 < 0 ? -y1 : y1) >= 839 * (x1 < 0 ? -x1 : x1);
    gstate = (dir_ok && steep0 && steep1) ? ST_SCROLL : ST_TWO;
  endtask

  task automatic predict_event(input touch_ev_t e);
    gesture_msg_t res[$];
    gesture_msg_t w;
    int f, px, py, sdx, sdy, mdx, mdy, thr, r;
    longint unsigned m;
    f = e.finger;
    px = int'($signed(e.x));
    py = int'($signed(e.y));
    thr = thr_reg;
    case (e.op)
      OP_TICK: begin
        if (tap_armed) begin
          if (tap_left <= 1) begin
            tap_left = 0;
            tap_armed = 1'b0;
            if (gstate != ST_DRAGSTART && gstate != ST_DOUBLE) begin
              res.insert(res.size(), gesture_word(ST_LEFT));
              if (gstate == ST_POTDBL) gstate = ST_IDLE;
            end
          end else begin
            tap_left--;
          end
        end
      end
      OP_DOWN: begin
        if (!active[f]) begin
          case (gstate)
            ST_IDLE:   gstate = ST_LEFT;
            ST_POTDBL: gstate = ST_DOUBLE;
            ST_MOVE:   gstate = ST_ADDMOVE;
            ST_LEFT:   gstate = ST_RIGHT;
            ST_RIGHT:  gstate = ST_SEARCH;
            ST_SEARCH: gstate = ST_ACTION;
            default: ;
          endcase
          rank[f] = fingers_down();
          active[f] = 1'b1;
          sx[f] = px; sy[f] = py; lx[f] = px; ly[f] = py;
        end
      end
      OP_MOVE: begin
        if (active[f]) begin
          sdx = px - sx[f]; sdy = py - sy[f];
          mdx = px - lx[f]; mdy = py - ly[f];
          lx[f] = px; ly[f] = py;
          if (sdx > thr || -sdx > thr || sdy > thr || -sdy > thr) begin
            case (gstate)
              ST_LEFT: gstate = ST_MOVE;
              ST_DOUBLE: begin
                gstate = ST_DRAGSTART;
                res.insert(res.size(), gesture_word(ST_DRAGSTART));
              end
              ST_RIGHT, ST_ADDMOVE: begin
                cls_count = cls_count + 4'd1;
                if (cls_count >= interval_reg) begin
                  cls_count = '0;
                  classify_two();
                end
              end
              ST_SEARCH: gstate = ST_THREE;
              ST_ACTION: gstate = ST_FOUR;
              default: ;
            endcase
          end
          if (gstate == ST_MOVE || gstate == ST_DRAGSTART) begin
            m = root_rounded(longint'(mdx) * mdx + longint'(mdy) * mdy);
            if (m > GAIN_TABLE_DEPTH - 1) m = GAIN_TABLE_DEPTH - 1;
            w.code = '0;
            w.dx = apply_gain(mdx, gain_lut[m]);
            w.dy = apply_gain(-mdy, gain_lut[m]);
            w.last = 1'b0;
            res.insert(res.size(), w);
          end
        end
      end
      OP_UP: begin
        if (active[f]) begin
          r = rank[f];
          active[f] = 1'b0;
          for (int i = 0; i < MAX_FINGERS; i++)
            if (active[i] && rank[i] > r) rank[i]--;
          if (fingers_down() == 0) begin
            if (gstate == ST_LEFT) begin
              gstate = ST_POTDBL;
              tap_armed = 1'b1;
              tap_left = tap_window_reg;
            end else begin
              if (gstate == ST_DOUBLE) gstate = ST_LEFT;
              else if (gstate == ST_DRAGSTART) gstate = ST_DRAGEND;
              else if (gstate == ST_MOVE) gstate = ST_IDLE;
              res.insert(res.size(), gesture_word(gstate));
              gstate = ST_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_msgs.insert(expected_msgs.size(), res[i]);
  endtask

  task automatic mismatch_report(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_event(pending_events.pop_front());
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {5'd0, pending_events[0].y, pending_events[0].x,
                             pending_events[0].finger};
          s_axis_tuser_i <= pending_events[0].op;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !rx_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_msgs.size() == 0) begin
        mismatch_report("unexpected word, code", m_axis_tuser_o, 0);
      end else begin
        if (m_axis_tuser_o !== expected_msgs[0].code)
          mismatch_report("msg_code", m_axis_tuser_o, expected_msgs[0].code);
        if (m_axis_tdata_o[15:0] !== expected_msgs[0].dx)
          mismatch_report("move_dx", m_axis_tdata_o[15:0], expected_msgs[0].dx);
        if (m_axis_tdata_o[31:16] !== expected_msgs[0].dy)
          mismatch_report("move_dy", m_axis_tdata_o[31:16], expected_msgs[0].dy);
        if (m_axis_tlast_o !== expected_msgs[0].last)
          mismatch_report("last", m_axis_tlast_o, expected_msgs[0].last);
        void'(expected_msgs.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("[touch_gesture_recognizer] ERROR");
      $finish;
    end
  end

  task automatic add_event(input tgr_op_e op, input int f, input int x, input int y);
    touch_ev_t e;
    e.op = op;
    e.finger = 3'(f);
    e.x = 16'(x);
    e.y = 16'(y);
    pending_events.insert(pending_events.size(), e);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(value);
    case (idx)
      CFG_MOVE_THR: thr_reg = 12'(value);
      CFG_CLS_INT:  interval_reg = 4'(value);
      CFG_TAP_WIN:  tap_window_reg = 16'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_events.size() != 0 || s_axis_tvalid_i || expected_msgs.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic gesture_session(inout int count);
    int nf, mode, steps, k, dx, dy, ticks;
    int fing[4], cx[4], cy[4];
    logic used[MAX_FINGERS];
    foreach (used[i]) used[i] = 1'b0;
    nf = ($urandom_range(2) == 0) ? 1 : $urandom_range(1, 4);
    for (int i = 0; i < nf; i++) begin
      do fing[i] = $urandom_range(MAX_FINGERS - 1); while (used[fing[i]]);
      used[fing[i]] = 1'b1;
      cx[i] = $urandom_range(4000) - 2000;
      cy[i] = $urandom_range(4000) - 2000;
      add_event(OP_DOWN, fing[i], cx[i], cy[i]);
    end
    if (nf == 1 && $urandom_range(2) == 0) begin
      add_event(OP_UP, fing[0], 0, 0);
      add_event(OP_DOWN, fing[0], cx[0], cy[0]);
      count += 2;
    end
    mode = $urandom_range(2);
    dx = $urandom_range(160) - 80;
    dy = $urandom_range(160) - 80;
    steps = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 14);
    for (int s = 0; s < steps; s++) begin
      k = $urandom_range(nf - 1);
      if (mode == 2) begin
        cx[k] += $urandom_range(160) - 80;
        cy[k] += $urandom_range(160) - 80;
      end else begin
        cx[k] += (mode == 1 && k[0]) ? -dx : dx;
        cy[k] += (mode == 1 && k[0]) ? -dy : dy;
        cx[k] += $urandom_range(8) - 4;
      end
      add_event(OP_MOVE, fing[k], cx[k], cy[k]);
      if ($urandom_range(15) == 0) begin
        add_event(tgr_op_e'($urandom_range(3)), $urandom_range(7), $urandom, $urandom);
        count++;
      end
    end
    for (int i = 0; i < nf; i++) add_event(OP_UP, fing[(i + mode) % nf], 0, 0);
    ticks = $urandom_range(0, (tap_window_reg > 10) ? 12 : tap_window_reg + 2);
    for (int i = 0; i < ticks; i++) add_event(OP_TICK, $urandom_range(7), $urandom, $urandom);
    count += 2 * nf + steps + ticks;
  endtask

  int thr_set[8]  = '{48, 0, 4095, 20, 48, 100, 30, 48};
  int int_set[8]  = '{5, 1, 15, 0, 2, 3, 1, 7};
  int tap_set[8]  = '{250, 1, 6, 0, 3, 2, 65535, 4};
  int sidle_set[8] = '{0, 45, 0, 45, 33, 0, 45, 33};
  int ridle_set[8] = '{0, 0, 45, 45, 33, 0, 33, 45};

  initial begin
    int n;
    gain_lut[0] = 0;
    for (int i = 1; i < GAIN_TABLE_DEPTH; i++)
      gain_lut[i] = int'((pow2_fix(((log2_fix(60 * i) - (64'd4 << 16)) * 13) / 20) * 512
                         + (64'd5 << 29)) / (64'd5 << 30));
    thr_reg = 12'd48;
    interval_reg = 4'd5;
    tap_window_reg = 16'd250;
    gstate = ST_IDLE;
    cls_count = '0;
    tap_left = 0;
    tap_armed = 1'b0;
    foreach (active[i]) begin
      active[i] = 1'b0;
      rank[i] = 0;
      sx[i] = 0; sy[i] = 0; lx[i] = 0; ly[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Directed part with a zero classify interval and a zero tap window.
    write_reg(CFG_MOVE_THR, 48);
    write_reg(CFG_CLS_INT, 0);
    write_reg(CFG_TAP_WIN, 0);
    add_event(OP_DOWN, 0, -32768, -32768);
    add_event(OP_MOVE, 0, 32767, 32767);
    add_event(OP_MOVE, 0, -32768, 32767);
    add_event(OP_UP, 0, 0, 0);
    add_event(OP_DOWN, 3, 100, 100);
    add_event(OP_UP, 3, 0, 0);
    add_event(OP_TICK, 7, 0, 0);
    add_event(OP_DOWN, 2, 0, 0);
    add_event(OP_UP, 2, 0, 0);
    add_event(OP_DOWN, 2, 0, 0);
    add_event(OP_MOVE, 2, 0, 200);
    add_event(OP_UP, 2, 0, 0);
    add_event(OP_TICK, 0, 0, 0);
    add_event(OP_DOWN, 0, 0, 0);
    add_event(OP_DOWN, 1, 500, 0);
    add_event(OP_MOVE, 0, 100, 0);
    add_event(OP_MOVE, 1, 400, 0);
    add_event(OP_UP, 0, 0, 0);
    add_event(OP_UP, 1, 0, 0);
    add_event(OP_DOWN, 5, 0, 0);
    add_event(OP_DOWN, 5, 9, 9);
    add_event(OP_MOVE, 6, 900, 900);
    add_event(OP_UP, 6, 0, 0);
    add_event(OP_UP, 5, 0, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_MOVE_THR, thr_set[p]);
      write_reg(CFG_CLS_INT, int_set[p]);
      write_reg(CFG_TAP_WIN, tap_set[p]);
      send_idle = sidle_set[p];
      recv_idle = ridle_set[p];
      n = 0;
      if (p == 2) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (400) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      while (n < 95) begin
        if ($urandom_range(7) == 0) begin
          add_event(tgr_op_e'($urandom_range(3)), $urandom_range(7), $urandom, $urandom);
          n++;
        end else begin
          gesture_session(n);
        end
        if (p % 2 == 1 && $urandom_range(9) == 0) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("[touch_gesture_recognizer] OK");
    end else begin
      $display("[touch_gesture_recognizer] ERROR");
    end
    $finish;
  end

endmodule
